>>> rtl/pgg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_pkg
// Shared types, constants and tables for the polar go-to-goal controller.
// ----------------------------------------------------------------------------
package pgg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int SQRT_STEPS   = 25;             // result bits of the root
  localparam int SQ_W         = 2 * SQRT_STEPS; // radicand width
  localparam int SQ_TOP       = SQ_W - 2;       // exponent of the top trial bit
  localparam int CHAIN_LEN    = SQRT_STEPS;     // covers every CORDIC step too
  localparam int IDX_W        = 5;

  localparam int ANG_PI     = 205887;
  localparam int ANG_TWO_PI = 411775;
  localparam int ANG_PI_4   = 51472;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEADING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FINAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_TOL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_TOL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT    = 3'd6;

  typedef struct packed {
    logic               valid;
    logic               reached;
    logic               zero;   // dx = dy = 0, angle taken as 0
    logic signed [18:0] th;
    logic signed [18:0] gth;
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [19:0] z;
    logic [SQ_W-1:0]    num;
    logic [SQ_W-1:0]    res;
  } cell_t;

  function automatic logic [15:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pgg_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_cell
// One link of the chain: a CORDIC vectoring step (only for idx below CORDIC_N) and one root digit.
// ----------------------------------------------------------------------------
module pgg_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic [pgg_pkg::IDX_W-1:0] idx,
  input  wire pgg_pkg::cell_t        din,
  output pgg_pkg::cell_t             dout
);
  import pgg_pkg::*;

  logic signed [27:0] xs, ys;
  logic [5:0]         sh;
  logic [SQ_W-1:0]    trial_bit, trial;
  logic signed [19:0] ang;
  cell_t              nxt;

  always_comb begin
    xs        = din.x >>> idx;
    ys        = din.y >>> idx;
    ang       = signed'({4'b0, atan_entry(idx)});
    sh        = 6'(SQ_TOP) - {idx, 1'b0};
    trial_bit = SQ_W'(1) << sh;
    trial     = din.res + trial_bit;
    nxt       = din;
    if (idx < IDX_W'(CORDIC_N)) begin
      if (din.y >= 0) begin
        nxt.x = din.x + ys;
        nxt.y = din.y - xs;
        nxt.z = din.z + ang;
      end else begin
        nxt.x = din.x - ys;
        nxt.y = din.y + xs;
        nxt.z = din.z - ang;
      end
    end
    if (din.num >= trial) begin
      nxt.num = din.num - trial;
      nxt.res = (din.res >> 1) + trial_bit;
    end else begin
      nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.reached <= nxt.reached;
      dout.zero    <= nxt.zero;
      dout.th      <= nxt.th;
      dout.gth     <= nxt.gth;
      dout.x       <= nxt.x;
      dout.y       <= nxt.y;
      dout.z       <= nxt.z;
      dout.num     <= nxt.num;
      dout.res     <= nxt.res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pgg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_back
// Angle wrap, gain products, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module pgg_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire pgg_pkg::cell_t din,
  input  wire logic [23:0]    gain_distance,
  input  wire logic [23:0]    gain_heading,
  input  wire logic [23:0]    gain_final_angle,
  input  wire logic [20:0]    forward_limit,
  input  wire logic [20:0]    turn_limit,
  output logic                out_valid,
  output logic signed [21:0]  forward_velocity,
  output logic signed [21:0]  turn_velocity,
  output logic                reached
);
  import pgg_pkg::*;

  // wrap stage
  logic signed [21:0] a_raw, a_w, b_raw, b_1, b_2, a_abs;
  logic               v0, r0, kill0;
  logic signed [21:0] alpha0, beta0;
  logic [24:0]        rho0;

  always_comb begin
    a_raw = (din.zero ? 22'sd0 : 22'(din.z)) - 22'(din.th);
    if (a_raw > 22'sd205887)        a_w = a_raw - 22'sd411775;
    else if (a_raw <= -22'sd205887) a_w = a_raw + 22'sd411775;
    else                            a_w = a_raw;
    b_raw = 22'(din.gth) - a_w - 22'(din.th);
    if (b_raw > 22'sd205887)        b_1 = b_raw - 22'sd411775;
    else if (b_raw <= -22'sd205887) b_1 = b_raw + 22'sd411775;
    else                            b_1 = b_raw;
    if (b_1 > 22'sd205887)          b_2 = b_1 - 22'sd411775;
    else if (b_1 <= -22'sd205887)   b_2 = b_1 + 22'sd411775;
    else                            b_2 = b_1;
    a_abs = (a_w < 0) ? -a_w : a_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0     <= din.reached;
      alpha0 <= a_w;
      beta0  <= b_2;
      rho0   <= din.res[24:0];
      kill0  <= a_abs > 22'(ANG_PI_4);
    end
  end

  // product stage
  logic               v1, r1, kill1;
  logic [48:0]        pf1;
  logic signed [46:0] pa1, pb1;

  always_ff @(posedge clk) begin
    if (en) begin
      r1    <= r0;
      kill1 <= kill0;
      pf1   <= rho0 * gain_distance;
      pa1   <= alpha0 * signed'({1'b0, gain_heading});
      pb1   <= beta0 * signed'({1'b0, gain_final_angle});
    end
  end

  // round and saturate
  logic [49:0]        fsum;
  logic [33:0]        fq;
  logic signed [48:0] tsum;
  logic signed [32:0] tq, tlim;
  logic [21:0]        fsat;
  logic signed [21:0] tsat;

  always_comb begin
    fsum = 50'(pf1) + 50'd32768;
    fq   = fsum[49:16];
    if (kill1)                        fsat = 22'd0;
    else if (fq > 34'(forward_limit)) fsat = 22'(forward_limit);
    else                              fsat = fq[21:0];
    tsum = 49'(pa1) + 49'(pb1) + 49'sd32768;
    tq   = tsum[48:16];
    tlim = signed'({12'b0, turn_limit});
    if (tq > tlim)       tsat = tlim[21:0];
    else if (tq < -tlim) tsat = 22'(-tlim);
    else                 tsat = tq[21:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reached          <= r1;
      forward_velocity <= r1 ? 22'sd0 : signed'(fsat);
      turn_velocity    <= r1 ? 22'sd0 : tsat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= din.valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/polar_go_to_goal_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_go_to_goal_controller
// Pose and goal in, forward and turn commands plus a reached flag out.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_axis  | in  | poses and goals (tdata), is_final (tuser)
//  m_axis  | out | forward and turn velocity (tdata), reached (tuser)
//  cfg     | in  | register write, index and data, no read-back
//
// One beat per cycle while the output is not stalled; each beat passes the front stage,
// the chain of CORDIC/root cells (one root digit per cell) and the back end.
// The whole pipeline advances together; a stalled output beat holds every
// stage and drops s_axis_tready. rst (synchronous) clears the valid bits
// and loads the register defaults.
module polar_go_to_goal_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [23:0] pose_x, [47:24] pose_y, [66:48] pose_heading, [90:67] goal_x,
  // [114:91] goal_y, [133:115] goal_heading, [135:134] zero
  input  wire logic [135:0] s_axis_tdata,
  // [0] is_final
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [21:0] forward_velocity, [43:22] turn_velocity, [47:44] zero
  output logic [47:0]       m_axis_tdata,
  // [0] reached
  output logic              m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  import pgg_pkg::*;

  logic [23:0] gain_distance, gain_heading, gain_final_angle;
  logic [20:0] end_tolerance, mid_tolerance, forward_limit, turn_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_distance    <= 24'd65536;
      gain_heading     <= 24'd163840;
      gain_final_angle <= 24'd6554;
      end_tolerance    <= 21'd1311;
      mid_tolerance    <= 21'd5243;
      forward_limit    <= 21'd19661;
      turn_limit       <= 21'd137258;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_DISTANCE: gain_distance    <= cfg_data;
        REG_GAIN_HEADING:  gain_heading     <= cfg_data;
        REG_GAIN_FINAL:    gain_final_angle <= cfg_data;
        REG_END_TOL:       end_tolerance    <= cfg_data[20:0];
        REG_MID_TOL:       mid_tolerance    <= cfg_data[20:0];
        REG_FWD_LIMIT:     forward_limit    <= cfg_data[20:0];
        REG_TURN_LIMIT:    turn_limit       <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // front stage: differences and tolerance test
  logic signed [24:0] dx_c, dy_c, adx, ady;
  logic [20:0]        tol;
  logic               v_a, reached_a;
  logic signed [24:0] dx_a, dy_a;
  logic signed [18:0] th_a, gth_a;

  always_comb begin
    dx_c = 25'(signed'(s_axis_tdata[90:67]))  - 25'(signed'(s_axis_tdata[23:0]));
    dy_c = 25'(signed'(s_axis_tdata[114:91])) - 25'(signed'(s_axis_tdata[47:24]));
    adx  = (dx_c < 0) ? -dx_c : dx_c;
    ady  = (dy_c < 0) ? -dy_c : dy_c;
    tol  = s_axis_tuser ? end_tolerance : mid_tolerance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a      <= dx_c;
      dy_a      <= dy_c;
      th_a      <= signed'(s_axis_tdata[66:48]);
      gth_a     <= signed'(s_axis_tdata[133:115]);
      reached_a <= ($unsigned(adx) < 25'(tol)) && ($unsigned(ady) < 25'(tol));
    end
  end

  // squares and quadrant fold into the head of the chain
  cell_t              link [0:CHAIN_LEN];
  cell_t              head;
  logic signed [49:0] sqx, sqy;

  always_comb begin
    sqx          = dx_a * dx_a;
    sqy          = dy_a * dy_a;
    head.valid   = v_a;
    head.reached = reached_a;
    head.zero    = (dx_a == 0) && (dy_a == 0);
    head.th      = th_a;
    head.gth     = gth_a;
    head.num     = sqx + sqy;
    head.res     = '0;
    if (dx_a < 0) begin
      head.x = -28'(dx_a);
      head.y = -28'(dy_a);
      head.z = (dy_a >= 0) ? 20'sd205887 : -20'sd205887;
    end else begin
      head.x = 28'(dx_a);
      head.y = 28'(dy_a);
      head.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link[0].valid <= 1'b0;
    end else if (en) begin
      link[0].valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      link[0].reached <= head.reached;
      link[0].zero    <= head.zero;
      link[0].th      <= head.th;
      link[0].gth     <= head.gth;
      link[0].x       <= head.x;
      link[0].y       <= head.y;
      link[0].z       <= head.z;
      link[0].num     <= head.num;
      link[0].res     <= head.res;
    end
  end

  for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
    pgg_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .idx  (IDX_W'(g)),
      .din  (link[g]),
      .dout (link[g+1])
    );
  end

  logic signed [21:0] fwd, turn;
  logic               reached;

  pgg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .din              (link[CHAIN_LEN]),
    .gain_distance    (gain_distance),
    .gain_heading     (gain_heading),
    .gain_final_angle (gain_final_angle),
    .forward_limit    (forward_limit),
    .turn_limit       (turn_limit),
    .out_valid        (m_axis_tvalid),
    .forward_velocity (fwd),
    .turn_velocity    (turn),
    .reached          (reached)
  );

  assign m_axis_tdata = {4'b0, turn, fwd};
  assign m_axis_tuser = reached;

endmodule
`default_nettype wire
